// ===== hw/rtl/lr_pkg.sv =====
package lr_pkg;

  // Default coordinate width of the endpoint and pixel fields
  localparam int COORD_BITS = 12;

  // Item kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  // Walk direction picked at line start (x always runs non-decreasing)
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP,
    OCT_SHALLOW_DOWN,
    OCT_STEEP_UP,
    OCT_STEEP_DOWN
  } octant_e;

endpackage

// ===== hw/rtl/lr_if.sv =====
// Input channel: line start / next pixel requests
interface lr_in_if #(
  parameter int CoordBits = lr_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [CoordBits-1:0] x_start;
  logic signed [CoordBits-1:0] y_start;
  logic signed [CoordBits-1:0] x_end;
  logic signed [CoordBits-1:0] y_end;

  modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

// Output channel: at most one pixel per item
interface lr_out_if #(
  parameter int CoordBits = lr_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] pixel_x;
  logic signed [CoordBits-1:0] pixel_y;
  logic                        last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== hw/rtl/lr_setup.sv =====
module lr_setup #(
  parameter int CoordBits = lr_pkg::COORD_BITS,
  parameter int StepBits  = CoordBits + 2,
  parameter int DecBits   = CoordBits + 4
) (
  input  logic signed [CoordBits-1:0] x_start_i,
  input  logic signed [CoordBits-1:0] y_start_i,
  input  logic signed [CoordBits-1:0] x_end_i,
  input  logic signed [CoordBits-1:0] y_end_i,
  output logic signed [CoordBits-1:0] cur_x_o,
  output logic signed [CoordBits-1:0] cur_y_o,
  output logic signed [CoordBits-1:0] stop_x_o,
  output logic signed [CoordBits-1:0] stop_y_o,
  output logic signed [StepBits-1:0]  step_a_o,
  output logic signed [StepBits-1:0]  step_b_o,
  output logic signed [DecBits-1:0]   decision_o,
  output lr_pkg::octant_e             octant_o
);

  logic                        swap;
  logic signed [CoordBits-1:0] x0, y0, x1, y1;
  logic signed [CoordBits:0]   dx, dy;
  logic        [CoordBits:0]   abs_dy;
  logic signed [DecBits-1:0]   dx_w, dy_w;
  logic                        shallow, rising;

  // Order endpoints so x runs non-decreasing
  assign swap = x_start_i > x_end_i;
  assign x0   = swap ? x_end_i   : x_start_i;
  assign y0   = swap ? y_end_i   : y_start_i;
  assign x1   = swap ? x_start_i : x_end_i;
  assign y1   = swap ? y_start_i : y_end_i;

  // Span on each axis; dx is never negative after the swap
  assign dx     = (CoordBits+1)'(x1) - (CoordBits+1)'(x0);
  assign dy     = (CoordBits+1)'(y1) - (CoordBits+1)'(y0);
  assign abs_dy = dy[CoordBits] ? (CoordBits+1)'(-dy) : (CoordBits+1)'(dy);
  assign dx_w   = DecBits'(dx);
  assign dy_w   = DecBits'(dy);

  assign shallow = $unsigned(dx) >= abs_dy;
  assign rising  = dy > 0;

  assign cur_x_o  = x0;
  assign cur_y_o  = y0;
  assign stop_x_o = x1;
  assign stop_y_o = y1;
  assign step_a_o = StepBits'(dy) <<< 1;
  assign step_b_o = -(StepBits'(dx) <<< 1);

  // Pick the walk case and seed the decision term
  always_comb begin
    if (shallow && rising) begin
      octant_o   = lr_pkg::OCT_SHALLOW_UP;
      decision_o = (dy_w <<< 1) - dx_w;
    end else if (shallow) begin
      octant_o   = lr_pkg::OCT_SHALLOW_DOWN;
      decision_o = (dy_w <<< 1) + dx_w;
    end else if (rising) begin
      octant_o   = lr_pkg::OCT_STEEP_UP;
      decision_o = dy_w - (dx_w <<< 1);
    end else begin
      octant_o   = lr_pkg::OCT_STEEP_DOWN;
      decision_o = dy_w + (dx_w <<< 1);
    end
  end

endmodule

// ===== hw/rtl/line_rasterizer_unit.sv =====
// Bresenham line rasterizer.
// in_i carries items of two kinds: a start item with two endpoints, which
// begins a new line (abandoning any line in progress) and yields its first
// pixel, and a next item, which yields the following pixel of the line.
// Each line gives span+1 pixels on out_o, the final one being the exact end
// point with last set. A next item while no line is open yields nothing.
// An accepted item waits in the input register and its pixel then goes to the
// output register. Throughput: one item per clock while out_o is ready; the line
// setup (swap, spans, decision seed) is computed ahead of the input register and
// the pixel step (end compare, sign test and narrow adds) sits between the
// input register and the output register, so back-to-back items stream freely.
// When the receiver stalls, the pixel holds in the output register, one
// more item waits in the input register, and in_i.ready then drops.
// Reset closes any open line and empties both registers.
module line_rasterizer_unit #(
  parameter int CoordBits = lr_pkg::COORD_BITS
) (
  input logic          clk_i,
  input logic          rst_ni,
  lr_in_if.sink        in_i,
  lr_out_if.source     out_o
);

  localparam int StepBits = CoordBits + 2;
  localparam int DecBits  = CoordBits + 4;

  // Setup results for a start item
  logic signed [CoordBits-1:0] su_cur_x, su_cur_y, su_stop_x, su_stop_y;
  logic signed [StepBits-1:0]  su_step_a, su_step_b;
  logic signed [DecBits-1:0]   su_dec;
  lr_pkg::octant_e             su_oct;

  // Input register
  logic                        s1_valid_q;
  logic                        s1_kind_q;
  logic signed [CoordBits-1:0] s1_cur_x_q, s1_cur_y_q, s1_stop_x_q, s1_stop_y_q;
  logic signed [StepBits-1:0]  s1_step_a_q, s1_step_b_q;
  logic signed [DecBits-1:0]   s1_dec_q;
  lr_pkg::octant_e             s1_oct_q;

  // Line state
  logic                        active_q;
  logic signed [CoordBits-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
  logic signed [StepBits-1:0]  step_a_q, step_b_q;
  logic signed [DecBits-1:0]   dec_q;
  lr_pkg::octant_e             oct_q;

  // Output register
  logic                        out_valid_q;
  logic signed [CoordBits-1:0] pix_x_q, pix_y_q;
  logic                        last_q;

  // Step datapath
  logic                        is_start, produce, out_free, s1_go, at_end, cond;
  logic signed [CoordBits-1:0] sel_x, sel_y, sel_sx, sel_sy, nx_x, nx_y;
  logic signed [StepBits-1:0]  sel_a, sel_b;
  logic signed [DecBits-1:0]   sel_dec, a_w, b_w, nx_dec;
  lr_pkg::octant_e             sel_oct;

  lr_setup #(
    .CoordBits (CoordBits),
    .StepBits  (StepBits),
    .DecBits   (DecBits)
  ) u_setup (
    .x_start_i  (in_i.x_start),
    .y_start_i  (in_i.y_start),
    .x_end_i    (in_i.x_end),
    .y_end_i    (in_i.y_end),
    .cur_x_o    (su_cur_x),
    .cur_y_o    (su_cur_y),
    .stop_x_o   (su_stop_x),
    .stop_y_o   (su_stop_y),
    .step_a_o   (su_step_a),
    .step_b_o   (su_step_b),
    .decision_o (su_dec),
    .octant_o   (su_oct)
  );

  // Handshake: a held item advances when it needs no output slot or one is free
  assign is_start   = s1_kind_q == lr_pkg::KIND_START;
  assign produce    = is_start || active_q;
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_go      = s1_valid_q && (out_free || !produce);
  assign in_i.ready = !s1_valid_q || s1_go;

  // Capture incoming item with its precomputed setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_kind_q   <= in_i.kind;
      s1_cur_x_q  <= su_cur_x;
      s1_cur_y_q  <= su_cur_y;
      s1_stop_x_q <= su_stop_x;
      s1_stop_y_q <= su_stop_y;
      s1_step_a_q <= su_step_a;
      s1_step_b_q <= su_step_b;
      s1_dec_q    <= su_dec;
      s1_oct_q    <= su_oct;
    end
  end

  // Pick fresh line setup on start, else the running state
  assign sel_x   = is_start ? s1_cur_x_q  : cur_x_q;
  assign sel_y   = is_start ? s1_cur_y_q  : cur_y_q;
  assign sel_sx  = is_start ? s1_stop_x_q : stop_x_q;
  assign sel_sy  = is_start ? s1_stop_y_q : stop_y_q;
  assign sel_a   = is_start ? s1_step_a_q : step_a_q;
  assign sel_b   = is_start ? s1_step_b_q : step_b_q;
  assign sel_dec = is_start ? s1_dec_q    : dec_q;
  assign sel_oct = is_start ? s1_oct_q    : oct_q;
  assign a_w     = DecBits'(sel_a);
  assign b_w     = DecBits'(sel_b);

  // Detect end point and step one pixel along the major axis
  always_comb begin
    at_end = 1'b0;
    cond   = 1'b0;
    nx_x   = sel_x;
    nx_y   = sel_y;
    nx_dec = sel_dec;
    case (sel_oct)
      lr_pkg::OCT_SHALLOW_UP: begin
        at_end = sel_x >= sel_sx;
        cond   = sel_dec > 0;
        nx_x   = sel_x + CoordBits'(1);
        nx_y   = sel_y + CoordBits'(cond);
        nx_dec = sel_dec + a_w + (cond ? b_w : '0);
      end
      lr_pkg::OCT_SHALLOW_DOWN: begin
        at_end = sel_x >= sel_sx;
        cond   = sel_dec < 0;
        nx_x   = sel_x + CoordBits'(1);
        nx_y   = sel_y - CoordBits'(cond);
        nx_dec = sel_dec + a_w - (cond ? b_w : '0);
      end
      lr_pkg::OCT_STEEP_UP: begin
        at_end = sel_y >= sel_sy;
        cond   = sel_dec < 0;
        nx_y   = sel_y + CoordBits'(1);
        nx_x   = sel_x + CoordBits'(cond);
        nx_dec = sel_dec + b_w + (cond ? a_w : '0);
      end
      lr_pkg::OCT_STEEP_DOWN: begin
        at_end = sel_y <= sel_sy;
        cond   = sel_dec > 0;
        nx_y   = sel_y - CoordBits'(1);
        nx_x   = sel_x + CoordBits'(cond);
        nx_dec = sel_dec - b_w + (cond ? a_w : '0);
      end
      default: begin
        at_end = 1'b1;
      end
    endcase
  end

  // Advance line state on each emitted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      stop_x_q <= '0;
      stop_y_q <= '0;
      step_a_q <= '0;
      step_b_q <= '0;
      dec_q    <= '0;
      oct_q    <= lr_pkg::OCT_SHALLOW_UP;
    end else if (s1_go && produce) begin
      active_q <= !at_end;
      cur_x_q  <= nx_x;
      cur_y_q  <= nx_y;
      stop_x_q <= sel_sx;
      stop_y_q <= sel_sy;
      step_a_q <= sel_a;
      step_b_q <= sel_b;
      dec_q    <= nx_dec;
      oct_q    <= sel_oct;
    end
  end

  // Output register: load a pixel, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && produce) begin
      pix_x_q <= at_end ? sel_sx : sel_x;
      pix_y_q <= at_end ? sel_sy : sel_y;
      last_q  <= at_end;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pixel_x = pix_x_q;
  assign out_o.pixel_y = pix_y_q;
  assign out_o.last    = last_q;

  // End point closes the line
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && produce && at_end |=> !active_q)
    else $error("line still open after end point");

  // Emitted pixel always lands in the output register
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && produce |=> out_valid_q && (last_q == $past(at_end)))
    else $error("emitted pixel missing from output register");

  // A stalled item stays put in the input register
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_kind_q) && $stable(s1_dec_q))
    else $error("held item overwritten");

  // The walk never passes the end point on its major axis
  a_no_overshoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |->
      ((oct_q == lr_pkg::OCT_SHALLOW_UP || oct_q == lr_pkg::OCT_SHALLOW_DOWN) &&
       cur_x_q <= stop_x_q) ||
      (oct_q == lr_pkg::OCT_STEEP_UP && cur_y_q <= stop_y_q) ||
      (oct_q == lr_pkg::OCT_STEEP_DOWN && cur_y_q >= stop_y_q))
    else $error("walk overshot end point");

endmodule
